// ----- sv/ups_pkg.sv -----
// ups_pkg: constants, character codes and controller/datapath interface structs
// for the URL path simplifier. No dependencies.
package ups_pkg;

    localparam int MAX_PATH_LEN = 256;
    localparam int ADDR_W       = $clog2(MAX_PATH_LEN);
    localparam int POS_W        = ADDR_W + 1;
    localparam int CHAR_W       = 8;

    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // latch path_char
        logic put;         // store byte at write position and emit it
        logic put_slash;   // byte is '/' instead of the latched char
        logic put_last;    // last result of this item
        logic drop;        // buffer full: set overflow
        logic check_load;  // load scan pointer from segment classification
        logic scan_step;   // step scan pointer back one byte
        logic resolve;     // commit new position to write_pos / segment_start
        logic finish;      // emit done result and clear path state
    } ups_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic phase_body;
        logic in_space;
        logic in_slash;
        logic in_zero;
        logic ch_zero;
        logic wp_full;
        logic is_dotdot;
        logic seg_zero;
        logic scan_done;
        logic out_free;
    } ups_status_t;

endpackage

// ----- sv/ups_dp.sv -----
// ups_dp: datapath of the URL path simplifier: path store, position registers,
// backward scan pointer and output register. Depends on ups_pkg.
module ups_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ups_pkg::ups_cmd_t            cmd,
    output ups_pkg::ups_status_t         status,
    input  logic [ups_pkg::CHAR_W-1:0]   path_char,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic                         write_valid,
    output logic [ups_pkg::ADDR_W-1:0]   write_index,
    output logic [ups_pkg::CHAR_W-1:0]   write_char,
    output logic                         done_res,
    output logic [ups_pkg::POS_W-1:0]    path_length,
    output logic                         overflow,
    output logic                         last
);

    localparam logic [ups_pkg::POS_W-1:0] MAX_POS = ups_pkg::POS_W'(ups_pkg::MAX_PATH_LEN);
    localparam logic [ups_pkg::POS_W-1:0] ONE     = ups_pkg::POS_W'(1);

    logic [ups_pkg::CHAR_W-1:0] path_store [ups_pkg::MAX_PATH_LEN];

    logic [ups_pkg::POS_W-1:0]  wp_reg, wp_next;
    logic [ups_pkg::POS_W-1:0]  seg_reg, seg_next;
    logic [ups_pkg::CHAR_W-1:0] prev_reg, prev_next;
    logic                       phase_reg, phase_next;
    logic                       ovf_reg, ovf_next;
    logic                       out_valid_reg, out_valid_next;

    logic [ups_pkg::POS_W-1:0]  np_reg, np_next;
    logic                       dotted_reg, dotted_next;
    logic [ups_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic [ups_pkg::CHAR_W-1:0] rd_reg;

    logic                       wv_reg, wv_next;
    logic [ups_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [ups_pkg::CHAR_W-1:0] wch_reg, wch_next;
    logic                       done_reg, done_next;
    logic [ups_pkg::POS_W-1:0]  len_reg, len_next;
    logic                       ovo_reg, ovo_next;
    logic                       last_reg, last_next;

    logic [ups_pkg::POS_W-1:0]  count;
    logic [ups_pkg::POS_W-1:0]  rd_addr;
    logic [ups_pkg::POS_W-1:0]  np_fin;
    logic [ups_pkg::CHAR_W-1:0] put_byte;
    logic                       is_dot;
    logic                       is_dotdot;
    logic                       out_free;

    assign count     = wp_reg - seg_reg;
    assign is_dotdot = (count == ups_pkg::POS_W'(3)) && (prev_reg == ups_pkg::CH_DOT)
                       && (rd_reg == ups_pkg::CH_DOT);
    assign is_dot    = (count == ONE)
                       || ((count == ups_pkg::POS_W'(2)) && (prev_reg == ups_pkg::CH_DOT));
    assign out_free  = !out_valid_reg || !out_stall;
    assign put_byte  = cmd.put_slash ? ups_pkg::CH_SLASH : ch_reg;
    assign np_fin    = np_reg + ((dotted_reg && (ch_reg == ups_pkg::CH_NUL)) ? ONE : '0);

    // read address: segment's second byte on accept, then the backward scan
    always_comb
    begin
        if (cmd.check_load)
        begin
            rd_addr = seg_reg - ONE;
        end
        else if (cmd.scan_step)
        begin
            rd_addr = np_reg - ONE;
        end
        else
        begin
            rd_addr = seg_reg + ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            path_store[wp_reg[ups_pkg::ADDR_W-1:0]] <= put_byte;
        end
        rd_reg <= path_store[rd_addr[ups_pkg::ADDR_W-1:0]];
    end

    always_comb
    begin
        wp_next        = wp_reg;
        seg_next       = seg_reg;
        prev_next      = prev_reg;
        phase_next     = phase_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        np_next        = np_reg;
        dotted_next    = dotted_reg;
        ch_next        = cmd.accept ? path_char : ch_reg;
        wv_next        = wv_reg;
        idx_next       = idx_reg;
        wch_next       = wch_reg;
        done_next      = done_reg;
        len_next       = len_reg;
        ovo_next       = ovo_reg;
        last_next      = last_reg;

        if (cmd.put)
        begin
            wp_next        = wp_reg + ONE;
            prev_next      = put_byte;
            phase_next     = 1'b1;
            out_valid_next = 1'b1;
            wv_next        = 1'b1;
            idx_next       = wp_reg[ups_pkg::ADDR_W-1:0];
            wch_next       = put_byte;
            done_next      = 1'b0;
            len_next       = '0;
            ovo_next       = ovf_reg;
            last_next      = cmd.put_last;
        end

        if (cmd.drop)
        begin
            ovf_next   = 1'b1;
            phase_next = 1'b1;
        end

        if (cmd.check_load)
        begin
            dotted_next = is_dotdot || is_dot;
            if (is_dotdot)
            begin
                np_next = (seg_reg == '0) ? '0 : seg_reg - ONE;
            end
            else if (is_dot)
            begin
                np_next = seg_reg;
            end
            else
            begin
                np_next = wp_reg;
            end
        end

        if (cmd.scan_step)
        begin
            np_next = np_reg - ONE;
        end

        if (cmd.resolve)
        begin
            wp_next  = np_fin;
            seg_next = np_fin;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            wv_next        = wp_reg < MAX_POS;
            idx_next       = (wp_reg < MAX_POS) ? wp_reg[ups_pkg::ADDR_W-1:0] : '0;
            wch_next       = ups_pkg::CH_NUL;
            done_next      = 1'b1;
            len_next       = wp_reg;
            ovo_next       = ovf_reg;
            last_next      = 1'b1;
            wp_next        = '0;
            seg_next       = '0;
            prev_next      = ups_pkg::CH_NUL;
            phase_next     = 1'b0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            seg_reg       <= '0;
            prev_reg      <= '0;
            phase_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            seg_reg       <= seg_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        np_reg     <= np_next;
        dotted_reg <= dotted_next;
        ch_reg     <= ch_next;
        wv_reg     <= wv_next;
        idx_reg    <= idx_next;
        wch_reg    <= wch_next;
        done_reg   <= done_next;
        len_reg    <= len_next;
        ovo_reg    <= ovo_next;
        last_reg   <= last_next;
    end

    assign status.phase_body = phase_reg;
    assign status.in_space   = path_char == ups_pkg::CH_SPACE;
    assign status.in_slash   = path_char == ups_pkg::CH_SLASH;
    assign status.in_zero    = path_char == ups_pkg::CH_NUL;
    assign status.ch_zero    = ch_reg == ups_pkg::CH_NUL;
    assign status.wp_full    = wp_reg >= MAX_POS;
    assign status.is_dotdot  = is_dotdot;
    assign status.seg_zero   = seg_reg == '0;
    assign status.scan_done  = (np_reg == '0) || (rd_reg == ups_pkg::CH_SLASH);
    assign status.out_free   = out_free;

    assign out_valid   = out_valid_reg;
    assign write_valid = wv_reg;
    assign write_index = idx_reg;
    assign write_char  = wch_reg;
    assign done_res    = done_reg;
    assign path_length = len_reg;
    assign overflow    = ovo_reg;
    assign last        = last_reg;

endmodule

// ----- sv/ups_ctrl.sv -----
// ups_ctrl: sequencing state machine of the URL path simplifier. Drives
// datapath commands from datapath status. Depends on ups_pkg.
module ups_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ups_pkg::ups_status_t status,
    output ups_pkg::ups_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PUT_PRE  = 3'd1;
    localparam logic [2:0] ST_PUT_CHAR = 3'd2;
    localparam logic [2:0] ST_CHECK    = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_RESOLVE  = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.phase_body)
                    begin
                        if (status.in_space)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (status.in_slash)
                        begin
                            state_next = ST_PUT_CHAR;
                        end
                        else
                        begin
                            state_next = ST_PUT_PRE;
                        end
                    end
                    else if (status.in_slash || status.in_zero)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_PUT_CHAR;
                    end
                end
            end
            ST_PUT_PRE:
            begin
                // leading slash: buffer is empty here, never full
                if (status.out_free)
                begin
                    cmd.put       = 1'b1;
                    cmd.put_slash = 1'b1;
                    state_next    = status.ch_zero ? ST_FINISH : ST_PUT_CHAR;
                end
            end
            ST_PUT_CHAR:
            begin
                if (status.wp_full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.put      = 1'b1;
                    cmd.put_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                cmd.check_load = 1'b1;
                state_next = (status.is_dotdot && !status.seg_zero) ? ST_SCAN : ST_RESOLVE;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = status.ch_zero ? ST_FINISH : ST_PUT_CHAR;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/url_path_simplifier_core.sv -----
// url_path_simplifier_core: top level of the URL path simplifier; joins the
// controller (ups_ctrl) and the datapath (ups_dp). Depends on ups_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_stall  | path_char
//   output  | out_valid / out_stall| write_valid write_index write_char done_res
//           |                      | path_length overflow last
//
// Per item: a leading space is skipped, an ordinary byte is stored, a first
// byte other than '/' is stored after a '/', and '/' or end of path closes the
// segment, walking back for a ".." that has a parent segment.
// The backward walk reads the path store one entry a cycle on its single
// read port. rst_n is asynchronous; the path store needs no clearing.
// A stalled output holds its item; the block waits before the next emit.
module url_path_simplifier_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ups_pkg::CHAR_W-1:0]         path_char,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               write_valid,
    output logic [ups_pkg::ADDR_W-1:0]         write_index,
    output logic [ups_pkg::CHAR_W-1:0]         write_char,
    output logic                               done_res,
    output logic [ups_pkg::POS_W-1:0]          path_length,
    output logic                               overflow,
    output logic                               last
);

    ups_pkg::ups_cmd_t    cmd;
    ups_pkg::ups_status_t status;

    ups_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ups_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .path_char   (path_char),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .write_valid (write_valid),
        .write_index (write_index),
        .write_char  (write_char),
        .done_res    (done_res),
        .path_length (path_length),
        .overflow    (overflow),
        .last        (last)
    );

    // the controller takes one item at a time (a skipped leading space does not stall)
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && path_char != ups_pkg::CH_SPACE) |=> in_stall)
        else $error("item accepted while previous item still in work");

    // only the done result may come without a buffer write
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_valid) |-> done_res)
        else $error("result without write that is not a done result");

    // done closes the item and its terminator lands at the path length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (last && (!write_valid
            || (write_index == path_length[ups_pkg::ADDR_W-1:0] && write_char == '0))))
        else $error("malformed done result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (path_length <= ups_pkg::POS_W'(ups_pkg::MAX_PATH_LEN)))
        else $error("path length beyond buffer size");

endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench for url_path_simplifier_core. Streams request
// paths byte by byte, predicts every buffer write and done item, checks them.
// Depends on ups_pkg and the url_path_simplifier_core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int TAIL_CHARS     = 200;
    localparam int RANDOM_CHARS   = 1640;

    typedef enum logic { SKIP_LEAD, TAKE_BODY } walk_phase_t;

    typedef struct {
        logic                       write_valid;
        logic [ups_pkg::ADDR_W-1:0] write_index;
        logic [ups_pkg::CHAR_W-1:0] write_char;
        logic                       done_res;
        logic [ups_pkg::POS_W-1:0]  path_length;
        logic                       overflow;
        logic                       last;
    } path_write_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [ups_pkg::CHAR_W-1:0] path_char = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       write_valid;
    logic [ups_pkg::ADDR_W-1:0] write_index;
    logic [ups_pkg::CHAR_W-1:0] write_char;
    logic                       done_res;
    logic [ups_pkg::POS_W-1:0]  path_length;
    logic                       overflow;
    logic                       last;

    url_path_simplifier_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .path_char   (path_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .write_index (write_index),
        .write_char  (write_char),
        .done_res    (done_res),
        .path_length (path_length),
        .overflow    (overflow),
        .last        (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // stimulus and expectations
    logic [ups_pkg::CHAR_W-1:0] char_q[$];
    path_write_t       expected_writes[$];
    int chars_total;
    int chars_taken;
    int lead_spaces;
    int npaths;
    int mismatches;
    int writes_checked;
    int paths_closed;
    int overflow_paths;
    int dotdot_walks;
    int drv_gap;
    int stall_gap;
    int quiet_cycles;
    logic tail_phase = 1'b0;

    // mirror of the block state
    logic [ups_pkg::CHAR_W-1:0] mirror_store [0:ups_pkg::MAX_PATH_LEN-1];
    int                         wr_pos;
    int                         seg_start;
    logic [ups_pkg::CHAR_W-1:0] prev_char;
    walk_phase_t                walk_phase;
    logic                       ovf_flag;
    int                         item_results;

    task automatic emit_write(input logic wv, input int idx,
                              input logic [ups_pkg::CHAR_W-1:0] ch,
                              input logic done, input int len);
        path_write_t r;
        r.write_valid = wv;
        r.write_index = wv ? idx[ups_pkg::ADDR_W-1:0] : '0;
        r.write_char  = wv ? ch : '0;
        r.done_res    = done;
        r.path_length = done ? len[ups_pkg::POS_W-1:0] : '0;
        r.overflow    = ovf_flag;
        r.last        = 1'b0;
        expected_writes.push_back(r);
        item_results++;
    endtask

    task automatic store_byte(input logic [ups_pkg::CHAR_W-1:0] ch);
        if (wr_pos < ups_pkg::MAX_PATH_LEN)
        begin
            mirror_store[wr_pos[ups_pkg::ADDR_W-1:0]] = ch;
            prev_char = ch;
            emit_write(1'b1, wr_pos, ch, 1'b0, 0);
            wr_pos++;
        end
        else
            ovf_flag = 1'b1;
    endtask

    task automatic close_path(input int len);
        if (len < ups_pkg::MAX_PATH_LEN)
            emit_write(1'b1, len, ups_pkg::CH_NUL, 1'b1, len);
        else
            emit_write(1'b0, 0, ups_pkg::CH_NUL, 1'b1, len);
        if (ovf_flag)
            overflow_paths++;
        wr_pos = 0;
        seg_start = 0;
        prev_char = '0;
        walk_phase = SKIP_LEAD;
        ovf_flag = 1'b0;
    endtask

    task automatic simplify_char(input logic [ups_pkg::CHAR_W-1:0] c);
        int seg;
        int cnt;
        int np;
        int second_pos;
        path_write_t tmp;
        item_results = 0;
        if (walk_phase == SKIP_LEAD)
        begin
            if (c == ups_pkg::CH_SPACE)
                return;
            wr_pos = 0;
            seg_start = 0;
            if (c != ups_pkg::CH_SLASH)
                store_byte(ups_pkg::CH_SLASH);
            if (c == ups_pkg::CH_NUL)
                close_path(wr_pos);
            else
            begin
                store_byte(c);
                walk_phase = TAKE_BODY;
            end
        end
        else if (c == ups_pkg::CH_SLASH || c == ups_pkg::CH_NUL)
        begin
            seg = seg_start;
            cnt = wr_pos - seg;
            np  = wr_pos;
            second_pos = seg + 1;
            if (cnt == 3 && prev_char == ups_pkg::CH_DOT
                && mirror_store[second_pos[ups_pkg::ADDR_W-1:0]] == ups_pkg::CH_DOT)
            begin
                // "..": back up to the slash before the previous segment
                dotdot_walks++;
                np = seg;
                if (np > 0)
                begin
                    np--;
                    while (np > 0 && mirror_store[np[ups_pkg::ADDR_W-1:0]] != ups_pkg::CH_SLASH)
                        np--;
                end
                if (c == ups_pkg::CH_NUL)
                    np++;
            end
            else if (cnt == 1 || (cnt == 2 && prev_char == ups_pkg::CH_DOT))
            begin
                // empty or lone "." segment
                np = seg;
                if (c == ups_pkg::CH_NUL)
                    np++;
            end
            seg_start = np;
            if (c == ups_pkg::CH_NUL)
                close_path(np);
            else
            begin
                wr_pos = np;
                store_byte(ups_pkg::CH_SLASH);
            end
        end
        else
            store_byte(c);
        if (item_results > 0)
        begin
            tmp = expected_writes[expected_writes.size() - 1];
            tmp.last = 1'b1;
            expected_writes[expected_writes.size() - 1] = tmp;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // stimulus builders
    function automatic logic [ups_pkg::CHAR_W-1:0] name_byte();
        logic [ups_pkg::CHAR_W-1:0] b;
        do
            b = ups_pkg::CHAR_W'($urandom_range(1, 255));
        while (b == ups_pkg::CH_SLASH);
        return b;
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            char_q.push_back(s[i]);
    endtask

    task automatic add_long_path(input int first_len, input int second_len, input bit up_tail);
        char_q.push_back(ups_pkg::CH_SLASH);
        repeat (first_len) char_q.push_back(name_byte());
        if (second_len > 0)
        begin
            char_q.push_back(ups_pkg::CH_SLASH);
            repeat (second_len) char_q.push_back(name_byte());
        end
        if (up_tail)
            push_str("/..");
        char_q.push_back(ups_pkg::CH_NUL);
    endtask

    task automatic add_random_path();
        int nseg;
        int n;
        n = $urandom_range(0, 2);
        repeat (n) char_q.push_back(ups_pkg::CH_SPACE);
        lead_spaces += n;
        if ($urandom_range(0, 7) == 0)
        begin
            // noise: any bytes
            repeat ($urandom_range(0, 12))
                char_q.push_back(ups_pkg::CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
                char_q.push_back(ups_pkg::CH_SLASH);
            nseg = $urandom_range(0, 7);
            for (int i = 0; i < nseg; i++)
            begin
                if (i > 0)
                    char_q.push_back(ups_pkg::CH_SLASH);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: repeat ($urandom_range(1, 5)) char_q.push_back(name_byte());
                    4:          push_str(".");
                    5, 6:       push_str("..");
                    7:          ;
                    8:
                    begin
                        repeat ($urandom_range(1, 3)) char_q.push_back(name_byte());
                        push_str(".");
                    end
                    default:    push_str("...");
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                char_q.push_back(ups_pkg::CH_SLASH);
        end
        char_q.push_back(ups_pkg::CH_NUL);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            path_char  <= '0;
            drv_gap    <= 0;
            tail_phase <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                simplify_char(path_char);
                chars_taken++;
            end
            tail_phase <= (char_q.size() < TAIL_CHARS);
            if (!in_valid || !in_stall)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap  <= drv_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!tail_phase && char_q.size() > 0 && $urandom_range(0, 11) == 0)
                begin
                    drv_gap  <= $urandom_range(0, 18);
                    in_valid <= 1'b0;
                end
                else if (char_q.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    path_char <= char_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("item with no expectation: index %0d char %0d done %0d",
                           write_index, write_char, done_res);
                    mismatches++;
                end
                else
                begin
                    path_write_t e;
                    e = expected_writes.pop_front();
                    compare_field("write_valid", 32'(e.write_valid), 32'(write_valid));
                    compare_field("write_index", 32'(e.write_index), 32'(write_index));
                    compare_field("write_char", 32'(e.write_char), 32'(write_char));
                    compare_field("done_res", 32'(e.done_res), 32'(done_res));
                    compare_field("path_length", 32'(e.path_length), 32'(path_length));
                    compare_field("overflow", 32'(e.overflow), 32'(overflow));
                    compare_field("last", 32'(e.last), 32'(last));
                    writes_checked++;
                    if (e.done_res)
                        paths_closed++;
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap <= stall_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 11) == 0)
            begin
                stall_gap <= $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on progress of either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", quiet_cycles);
                $display("tb NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wr_pos = 0;
        seg_start = 0;
        prev_char = '0;
        walk_phase = SKIP_LEAD;
        ovf_flag = 1'b0;

        // directed: leading space then empty path
        push_str(" ");
        char_q.push_back(ups_pkg::CH_NUL);
        // dot-dot at root
        push_str("/..");
        char_q.push_back(ups_pkg::CH_NUL);
        // no leading slash, dotted names kept, trailing lone dot
        char_q.push_back(8'hFF);
        push_str("./.../.");
        char_q.push_back(ups_pkg::CH_NUL);
        // collapsed slashes, dot-dot removing the segment before it
        char_q.push_back(ups_pkg::CH_SLASH);
        char_q.push_back(8'h80);
        push_str("//..");
        char_q.push_back(ups_pkg::CH_NUL);
        lead_spaces = 1;

        while (char_q.size() - lead_spaces < RANDOM_CHARS)
        begin
            case (npaths)
                4:  add_long_path(255, 0, 1'b0);   // fills the buffer exactly
                12: add_long_path(254, 0, 1'b0);   // terminator lands in last entry
                20: add_long_path(5, 260, 1'b1);   // runs past the end
                28: add_long_path(3, 120, 1'b1);   // long backward walk
                default: add_random_path();
            endcase
            npaths++;
        end
        chars_total = char_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (chars_taken < chars_total)
            @(posedge clk);
        while (expected_writes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_writes.size() > 0)
        begin
            $error("%0d expected items never arrived", expected_writes.size());
            mismatches++;
        end
        $display("sent %0d path bytes over %0d paths; %0d closed, %0d overflowed, %0d '..' walks",
                 chars_total, npaths + 4, paths_closed, overflow_paths, dotdot_walks);
        $display("checked %0d output items, %0d mismatches", writes_checked, mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
